// ===== hw/rtl/fud_pkg.sv =====
// Shared types, constants and helper functions of the form-urlencoded decoder.
package fud_pkg;

   localparam int MaxResults = 3;
   localparam int QueueDepth = 4;
   localparam int PtrWidth   = $clog2(QueueDepth);
   localparam int CountWidth = $clog2(MaxResults + 1);

   localparam logic [7:0] CharPercent = 8'h25;
   localparam logic [7:0] CharPlus    = 8'h2b;
   localparam logic [7:0] CharEquals  = 8'h3d;
   localparam logic [7:0] CharAmp     = 8'h26;
   localparam logic [7:0] CharSpace   = 8'h20;

   typedef enum logic [1:0] {
      ESC_NONE  = 2'd0,
      ESC_PCT   = 2'd1,
      ESC_DIGIT = 2'd2
   } esc_type;

   // One decoded result; pair and string flags are carried once per bundle.
   typedef struct packed {
      logic [7:0] out_char;
      logic       has_char;
      logic       is_value;
   } slot_type;

   // All results caused by one accepted byte.
   typedef struct packed {
      logic [CountWidth-1:0]          count;
      slot_type [MaxResults-1:0]      slots;
      logic                           closed;
      logic                           fin;
   } bundle_type;

   function automatic logic is_hex(input logic [7:0] c);
      is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [7:0] v;
      v = 8'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = c - 8'h57;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = c - 8'h37;
      end
      hex_nibble = v[3:0];
   endfunction

   // Appends a result to a bundle; results beyond the limit are dropped.
   function automatic bundle_type push_slot(input bundle_type b, input logic [7:0] ch,
                                            input logic has, input logic isv);
      bundle_type r;
      r = b;
      if (r.count < CountWidth'(MaxResults)) begin
         r.slots[r.count] = '{out_char: ch, has_char: has, is_value: isv};
         r.count          = r.count + CountWidth'(1);
      end
      push_slot = r;
   endfunction

endpackage

// ===== hw/rtl/fud_front.sv =====
// Front end: classifies each byte, tracks name/value and escape state, builds a result bundle.
module fud_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         in_char,
   input  logic               in_final,
   output logic               push,
   output fud_pkg::bundle_type bundle
);

   logic              value_mode_ff, value_mode_in;
   fud_pkg::esc_type  escape_ff, escape_in;
   logic [7:0]        held_ff, held_in;

   always_comb begin
      fud_pkg::bundle_type b;
      logic vm;
      fud_pkg::esc_type st;
      logic [7:0] hd;
      logic closed;
      logic plain;

      b      = '0;
      vm     = value_mode_ff;
      st     = escape_ff;
      hd     = held_ff;
      closed = 1'b0;
      plain  = 1'b0;

      if (!vm) begin
         if (in_char == fud_pkg::CharEquals) begin
            vm = 1'b1;
         end else begin
            b = fud_pkg::push_slot(b, in_char, 1'b1, 1'b0);
         end
      end else begin
         unique case (st)
            fud_pkg::ESC_PCT: begin
               if (fud_pkg::is_hex(in_char)) begin
                  hd = in_char;
                  st = fud_pkg::ESC_DIGIT;
               end else begin
                  st    = fud_pkg::ESC_NONE;
                  b     = fud_pkg::push_slot(b, fud_pkg::CharPercent, 1'b1, 1'b1);
                  plain = 1'b1;
               end
            end
            fud_pkg::ESC_DIGIT: begin
               st = fud_pkg::ESC_NONE;
               if (fud_pkg::is_hex(in_char)) begin
                  b = fud_pkg::push_slot(b, {fud_pkg::hex_nibble(hd),
                                             fud_pkg::hex_nibble(in_char)}, 1'b1, 1'b1);
               end else begin
                  b     = fud_pkg::push_slot(b, fud_pkg::CharPercent, 1'b1, 1'b1);
                  b     = fud_pkg::push_slot(b, hd, 1'b1, 1'b1);
                  plain = 1'b1;
               end
            end
            default: begin
               plain = 1'b1;
            end
         endcase

         // The breaking byte of a malformed escape is decoded as an ordinary value byte.
         if (plain) begin
            if (in_char == fud_pkg::CharAmp) begin
               closed = 1'b1;
            end else if (in_char == fud_pkg::CharPercent) begin
               st = fud_pkg::ESC_PCT;
            end else if (in_char == fud_pkg::CharPlus) begin
               b = fud_pkg::push_slot(b, fud_pkg::CharSpace, 1'b1, 1'b1);
            end else begin
               b = fud_pkg::push_slot(b, in_char, 1'b1, 1'b1);
            end
         end
      end

      // An escape cut off by the end of the string is flushed literally.
      if (in_final && vm) begin
         if (st == fud_pkg::ESC_PCT) begin
            b = fud_pkg::push_slot(b, fud_pkg::CharPercent, 1'b1, 1'b1);
         end else if (st == fud_pkg::ESC_DIGIT) begin
            b = fud_pkg::push_slot(b, fud_pkg::CharPercent, 1'b1, 1'b1);
            b = fud_pkg::push_slot(b, hd, 1'b1, 1'b1);
         end
         st     = fud_pkg::ESC_NONE;
         closed = 1'b1;
      end

      if (closed) begin
         vm = 1'b0;
         st = fud_pkg::ESC_NONE;
      end
      if (in_final) begin
         vm = 1'b0;
         st = fud_pkg::ESC_NONE;
         hd = 8'd0;
      end

      if ((closed || in_final) && b.count == '0) begin
         b = fud_pkg::push_slot(b, 8'd0, 1'b0, closed);
      end
      b.closed = closed;
      b.fin    = in_final;

      bundle        = b;
      push          = accept && (b.count != '0);
      value_mode_in = accept ? vm : value_mode_ff;
      escape_in     = accept ? st : escape_ff;
      held_in       = accept ? hd : held_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_mode_ff <= 1'b0;
         escape_ff     <= fud_pkg::ESC_NONE;
         held_ff       <= 8'd0;
      end else begin
         value_mode_ff <= value_mode_in;
         escape_ff     <= escape_in;
         held_ff       <= held_in;
      end
   end

endmodule

// ===== hw/rtl/fud_queue.sv =====
// Short bundle queue that decouples the front end from the result sequencer.
module fud_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  fud_pkg::bundle_type push_data,
   input  logic                pop,
   output fud_pkg::bundle_type head,
   output logic                empty,
   output logic                full
);

   fud_pkg::bundle_type               mem_ff [fud_pkg::QueueDepth];
   logic [fud_pkg::PtrWidth-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [fud_pkg::PtrWidth-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [fud_pkg::PtrWidth:0]        fill_ff, fill_in;
   logic                              do_push, do_pop;

   assign empty   = (fill_ff == '0);
   assign full    = (fill_ff == (fud_pkg::PtrWidth + 1)'(fud_pkg::QueueDepth));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + fud_pkg::PtrWidth'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + fud_pkg::PtrWidth'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + (fud_pkg::PtrWidth + 1)'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - (fud_pkg::PtrWidth + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ===== hw/rtl/fud_back.sv =====
// Back end: steps through the results of each bundle into the output register.
module fud_back (
   input  logic                clock,
   input  logic                reset,
   input  fud_pkg::bundle_type head,
   input  logic                empty,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_char,
   output logic                rsp_has_char,
   output logic                rsp_is_value,
   output logic                rsp_pair_end,
   output logic                rsp_input_end,
   output logic                rsp_run_last
);

   logic [fud_pkg::CountWidth-1:0] idx_ff, idx_in;
   logic                           valid_ff, valid_in;
   fud_pkg::slot_type              slot_ff, slot_in;
   logic                           pair_end_ff, pair_end_in;
   logic                           input_end_ff, input_end_in;
   logic                           run_last_ff, run_last_in;
   logic                           load;
   logic                           last;

   assign load = !valid_ff || !rsp_stall;
   assign last = (idx_ff == head.count - fud_pkg::CountWidth'(1));

   always_comb begin
      idx_in       = idx_ff;
      valid_in     = valid_ff;
      slot_in      = slot_ff;
      pair_end_in  = pair_end_ff;
      input_end_in = input_end_ff;
      run_last_in  = run_last_ff;
      pop          = 1'b0;
      if (load) begin
         valid_in = !empty;
         if (!empty) begin
            slot_in      = head.slots[idx_ff];
            pair_end_in  = last && head.closed;
            input_end_in = last && head.fin;
            run_last_in  = last;
            pop          = last;
            idx_in       = last ? '0 : idx_ff + fud_pkg::CountWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      pair_end_ff  <= pair_end_in;
      input_end_ff <= input_end_in;
      run_last_ff  <= run_last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_char  = slot_ff.out_char;
   assign rsp_has_char  = slot_ff.has_char;
   assign rsp_is_value  = slot_ff.is_value;
   assign rsp_pair_end  = pair_end_ff;
   assign rsp_input_end = input_end_ff;
   assign rsp_run_last  = run_last_ff;

endmodule

// ===== hw/rtl/form_urlencoded_decoder_unit.sv =====
// Top level of the form-urlencoded decoder: front end, bundle queue and result sequencer.
//
//   Channel   Direction   Handshake             Payload
//   req       in          req_valid/req_stall   req_in_char, req_in_final
//   rsp       out         rsp_valid/rsp_stall   rsp_out_char, rsp_has_char, rsp_is_value,
//                                               rsp_pair_end, rsp_input_end, rsp_run_last
//
// One byte is taken per cycle while the bundle queue is not full; its results are queued and
// delivered one per cycle while rsp_stall is low (a byte gives 0 to 3 results).
// The results of an accepted byte pass through the bundle queue and then the output
// register before rsp_valid rises.
// req_stall rises only when the four-entry bundle queue is full.
// Synchronous reset returns to name mode with no escape pending and an empty queue.
module form_urlencoded_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_char,
   input  logic       req_in_final,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_has_char,
   output logic       rsp_is_value,
   output logic       rsp_pair_end,
   output logic       rsp_input_end,
   output logic       rsp_run_last
);

   fud_pkg::bundle_type bundle;
   fud_pkg::bundle_type head;
   logic                push;
   logic                pop;
   logic                empty;
   logic                full;
   logic                accept;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   fud_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .in_char  (req_in_char),
      .in_final (req_in_final),
      .push     (push),
      .bundle   (bundle)
   );

   fud_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (bundle),
      .pop       (pop),
      .head      (head),
      .empty     (empty),
      .full      (full)
   );

   fud_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .empty         (empty),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_has_char  (rsp_has_char),
      .rsp_is_value  (rsp_is_value),
      .rsp_pair_end  (rsp_pair_end),
      .rsp_input_end (rsp_input_end),
      .rsp_run_last  (rsp_run_last)
   );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the form-urlencoded decoder unit.
`timescale 1ns / 1ps

module testbench;

   localparam int ItemTarget    = 430;
   localparam int PauseAt       = 250;
   localparam int HoldTrigger   = 120;
   localparam int HoldCycles    = 300;
   localparam int WatchdogLimit = 2000;
   localparam int DrainCycles   = 8;

   typedef struct packed {
      logic [7:0] ch;
      logic       fin;
   } req_item_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       has;
      logic       isv;
      logic       pair_end;
      logic       input_end;
      logic       run_last;
   } decoded_type;

   logic       clock;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_char   = 8'h00;
   logic       req_in_final  = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall     = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_has_char;
   logic       rsp_is_value;
   logic       rsp_pair_end;
   logic       rsp_input_end;
   logic       rsp_run_last;

   req_item_type pending_q[$];
   decoded_type  expected_q[$];
   decoded_type  step_q[$];
   logic [7:0]   str_q[$];

   // Predictor state.
   logic             in_value  = 1'b0;
   fud_pkg::esc_type esc_state = fud_pkg::ESC_NONE;
   logic [7:0]       held_char = 8'h00;

   int queued_count   = 0;
   int accepted_count = 0;
   int results_seen   = 0;
   int errors         = 0;
   int gap_left       = 0;
   int burst_left     = 8;
   int hold_left      = 0;
   int phase_left     = 0;
   int stall_mode     = 0;
   int stall_tick     = 0;
   bit hold_done      = 1'b0;
   req_item_type next_item;
   decoded_type  got_res;
   decoded_type  want_res;

   form_urlencoded_decoder_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_char   (req_in_char),
      .req_in_final  (req_in_final),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_has_char  (rsp_has_char),
      .rsp_is_value  (rsp_is_value),
      .rsp_pair_end  (rsp_pair_end),
      .rsp_input_end (rsp_input_end),
      .rsp_run_last  (rsp_run_last)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic is_hex_digit(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c >= "0" && c <= "9") begin
         v = c - 8'h30;
      end else if (c >= "a" && c <= "f") begin
         v = c - 8'h57;
      end else if (c >= "A" && c <= "F") begin
         v = c - 8'h37;
      end
      return v[3:0];
   endfunction

   function automatic void add_result(input logic [7:0] ch, input logic has, input logic isv);
      decoded_type r;
      if (step_q.size() < fud_pkg::MaxResults) begin
         r = '{ch: ch, has: has, isv: isv, pair_end: 1'b0, input_end: 1'b0, run_last: 1'b0};
         step_q.push_back(r);
      end
   endfunction

   // Decodes a value byte with no escape pending; returns 1 when it closes the pair.
   function automatic logic decode_plain(input logic [7:0] c);
      decode_plain = 1'b0;
      if (c == fud_pkg::CharAmp) begin
         decode_plain = 1'b1;
      end else if (c == fud_pkg::CharPercent) begin
         esc_state = fud_pkg::ESC_PCT;
      end else if (c == fud_pkg::CharPlus) begin
         add_result(fud_pkg::CharSpace, 1'b1, 1'b1);
      end else begin
         add_result(c, 1'b1, 1'b1);
      end
   endfunction

   function automatic void predict_decode(input logic [7:0] c, input logic fin);
      logic        closed;
      decoded_type r;
      closed = 1'b0;
      step_q.delete();
      if (!in_value) begin
         if (c == fud_pkg::CharEquals) in_value = 1'b1;
         else add_result(c, 1'b1, 1'b0);
      end else begin
         case (esc_state)
            fud_pkg::ESC_NONE: begin
               closed = decode_plain(c);
            end
            fud_pkg::ESC_PCT: begin
               if (is_hex_digit(c)) begin
                  held_char = c;
                  esc_state = fud_pkg::ESC_DIGIT;
               end else begin
                  esc_state = fud_pkg::ESC_NONE;
                  add_result(fud_pkg::CharPercent, 1'b1, 1'b1);
                  closed = decode_plain(c);
               end
            end
            default: begin
               if (is_hex_digit(c)) begin
                  add_result({nibble_of(held_char), nibble_of(c)}, 1'b1, 1'b1);
                  esc_state = fud_pkg::ESC_NONE;
               end else begin
                  esc_state = fud_pkg::ESC_NONE;
                  add_result(fud_pkg::CharPercent, 1'b1, 1'b1);
                  add_result(held_char, 1'b1, 1'b1);
                  closed = decode_plain(c);
               end
            end
         endcase
      end
      // An escape cut short by the end of the string is flushed literally.
      if (fin && in_value) begin
         if (esc_state == fud_pkg::ESC_PCT) begin
            add_result(fud_pkg::CharPercent, 1'b1, 1'b1);
         end else if (esc_state == fud_pkg::ESC_DIGIT) begin
            add_result(fud_pkg::CharPercent, 1'b1, 1'b1);
            add_result(held_char, 1'b1, 1'b1);
         end
         esc_state = fud_pkg::ESC_NONE;
         closed    = 1'b1;
      end
      if (closed) begin
         in_value  = 1'b0;
         esc_state = fud_pkg::ESC_NONE;
      end
      if (fin) begin
         in_value  = 1'b0;
         esc_state = fud_pkg::ESC_NONE;
         held_char = 8'h00;
      end
      if ((closed || fin) && step_q.size() == 0) add_result(8'h00, 1'b0, closed);
      if (step_q.size() > 0) begin
         r           = step_q[step_q.size()-1];
         r.pair_end  = closed;
         r.input_end = fin;
         r.run_last  = 1'b1;
         step_q[step_q.size()-1] = r;
      end
      foreach (step_q[i]) expected_q.push_back(step_q[i]);
   endfunction

   function automatic logic [7:0] rand_alnum();
      case ($urandom_range(0, 2))
         0:       return 8'h61 + 8'($urandom_range(0, 25));
         1:       return 8'h41 + 8'($urandom_range(0, 25));
         default: return 8'h30 + 8'($urandom_range(0, 9));
      endcase
   endfunction

   function automatic logic [7:0] rand_hex();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) return 8'h30 + 8'(v);
      if ($urandom_range(0, 1) == 1) return 8'h41 + 8'(v - 10);
      return 8'h61 + 8'(v - 10);
   endfunction

   task automatic add_byte(input logic [7:0] c, input logic fin);
      pending_q.push_back('{ch: c, fin: fin});
      queued_count++;
   endtask

   // Builds one random string, mostly well-formed pairs, and queues it with its end flag.
   task automatic queue_random_string();
      int         pairs;
      int         n;
      int         kind;
      logic [7:0] c;
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 8);
         repeat (n) str_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         pairs = $urandom_range(1, 4);
         for (int p = 0; p < pairs; p++) begin
            if (p > 0) str_q.push_back(fud_pkg::CharAmp);
            n = $urandom_range(0, 5);
            repeat (n) begin
               c = ($urandom_range(0, 9) < 7) ? rand_alnum() : 8'($urandom_range(0, 255));
               if (c == fud_pkg::CharEquals) c = "x";
               str_q.push_back(c);
            end
            if ($urandom_range(0, 9) != 0) begin
               str_q.push_back(fud_pkg::CharEquals);
               n = $urandom_range(0, 6);
               repeat (n) begin
                  kind = $urandom_range(0, 9);
                  case (kind)
                     0, 1, 2: str_q.push_back(rand_alnum());
                     3:       str_q.push_back(fud_pkg::CharPlus);
                     4:       str_q.push_back(fud_pkg::CharEquals);
                     5, 6: begin
                        str_q.push_back(fud_pkg::CharPercent);
                        str_q.push_back(rand_hex());
                        str_q.push_back(rand_hex());
                     end
                     7: begin
                        str_q.push_back(fud_pkg::CharPercent);
                        if ($urandom_range(0, 1) == 1) str_q.push_back(rand_hex());
                        case ($urandom_range(0, 5))
                           0:       str_q.push_back(fud_pkg::CharPlus);
                           1:       str_q.push_back(fud_pkg::CharAmp);
                           2:       str_q.push_back(fud_pkg::CharPercent);
                           3:       str_q.push_back(fud_pkg::CharEquals);
                           4:       str_q.push_back("g");
                           default: str_q.push_back(8'($urandom_range(0, 255)));
                        endcase
                     end
                     8: str_q.push_back(8'($urandom_range(0, 255)));
                     default: begin
                        str_q.push_back(fud_pkg::CharPercent);
                        str_q.push_back(rand_hex());
                     end
                  endcase
               end
            end
         end
      end
      if (str_q.size() == 0) str_q.push_back(rand_alnum());
      foreach (str_q[i]) add_byte(str_q[i], i == str_q.size() - 1);
      str_q.delete();
   endtask

   task automatic wait_drained();
      while (accepted_count != queued_count || expected_q.size() != 0) @(posedge clock);
   endtask

   // Sender: bursts of random length separated by random gaps; a held item never changes.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_decode(req_in_char, req_in_final);
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               next_item = pending_q.pop_front();
               req_valid    <= 1'b1;
               req_in_char  <= next_item.ch;
               req_in_final <= next_item.fin;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall pattern, with one long hold-off that backs the block up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && results_seen >= HoldTrigger) begin
         hold_done = 1'b1;
         hold_left = HoldCycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (phase_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            phase_left = $urandom_range(16, 80);
         end else begin
            phase_left--;
         end
         stall_tick = (stall_tick + 1) % 5;
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 1) == 1);
            default: rsp_stall <= (stall_tick < 2);
         endcase
      end
   end

   // Monitor: every accepted result is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_res = {rsp_out_char, rsp_has_char, rsp_is_value,
                    rsp_pair_end, rsp_input_end, rsp_run_last};
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: char=%h has=%b value=%b pair_end=%b",
                     $time, got_res.ch, got_res.has, got_res.isv, got_res.pair_end,
                     " input_end=%b last=%b", got_res.input_end, got_res.run_last);
         end else begin
            want_res = expected_q.pop_front();
            if (got_res !== want_res) begin
               errors++;
               $display("%0t: mismatch: expected char=%h has=%b value=%b pair_end=%b",
                        $time, want_res.ch, want_res.has, want_res.isv, want_res.pair_end,
                        " input_end=%b last=%b", want_res.input_end, want_res.run_last);
               $display("%0t:           actual char=%h has=%b value=%b pair_end=%b",
                        $time, got_res.ch, got_res.has, got_res.isv, got_res.pair_end,
                        " input_end=%b last=%b", got_res.input_end, got_res.run_last);
            end
         end
         results_seen++;
      end
   end

   // Watchdog: ends the run when no transaction is accepted for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WatchdogLimit) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("FAIL form_urlencoded_decoder_unit");
      $finish;
   end

   initial begin : stimulus
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Extreme bytes and a kept ampersand in a name, then the value decodes.
      add_byte(8'h00, 1'b0);
      add_byte(8'hff, 1'b0);
      add_byte(fud_pkg::CharAmp, 1'b0);
      add_byte(fud_pkg::CharEquals, 1'b0);
      add_byte(fud_pkg::CharPlus, 1'b0);
      add_byte(fud_pkg::CharPercent, 1'b0);
      add_byte("4", 1'b0);
      add_byte("a", 1'b0);
      add_byte(fud_pkg::CharPercent, 1'b0);
      add_byte("F", 1'b0);
      add_byte("f", 1'b0);
      // Broken escape right after the percent sign.
      add_byte(fud_pkg::CharPercent, 1'b0);
      add_byte("z", 1'b0);
      // Broken escape after one digit, broken by the pair separator.
      add_byte(fud_pkg::CharPercent, 1'b0);
      add_byte("3", 1'b0);
      add_byte(fud_pkg::CharAmp, 1'b0);
      // Equals sign inside a value, then an escape cut by the end of the string.
      add_byte("k", 1'b0);
      add_byte(fud_pkg::CharEquals, 1'b0);
      add_byte(fud_pkg::CharEquals, 1'b0);
      add_byte(fud_pkg::CharPercent, 1'b0);
      add_byte("7", 1'b1);
      // Trailing name without an equals sign.
      add_byte("q", 1'b1);
      // Equals sign as the last byte.
      add_byte(fud_pkg::CharEquals, 1'b1);
      // Percent sign as the last byte.
      add_byte(fud_pkg::CharEquals, 1'b0);
      add_byte(fud_pkg::CharPercent, 1'b1);
      wait_drained();

      while (queued_count < PauseAt) queue_random_string();
      wait_drained();
      while (queued_count < ItemTarget) queue_random_string();
      wait_drained();
      repeat (DrainCycles) @(posedge clock);

      if (errors == 0 && expected_q.size() == 0) begin
         $display("PASS form_urlencoded_decoder_unit");
      end else begin
         $display("FAIL form_urlencoded_decoder_unit");
      end
      $finish;
   end

endmodule
